FILE: rtl/sbmq_pkg.sv
package sbmq_pkg;

    // Field widths fixed by the stream format
    localparam int CMD_W    = 1;
    localparam int QID_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // Queue_id reaches at most this many queue slots
    localparam int QSLOTS = 2 ** QID_W;

    // Operation codes
    localparam logic [CMD_W-1:0] CMD_ENQ = 1'b0;
    localparam logic [CMD_W-1:0] CMD_DEQ = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the input transfer and launch memory reads
        logic commit;    // apply pointer and memory updates, load the result
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // result register can take a new result this cycle
    } dp_stat_t;

endpackage

FILE: rtl/sbmq_ram.sv
module sbmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sbmq_ctrl.sv
module sbmq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sbmq_pkg::dp_stat_t   stat,
    output sbmq_pkg::ctrl_cmd_t  ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // Take a transfer only when idle
    assign in_ready    = (state_reg == S_IDLE);
    assign ctl.capture = in_valid && (state_reg == S_IDLE);
    assign ctl.commit  = (state_reg == S_EXEC) && stat.out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/sbmq_dp.sv
module sbmq_dp #(
    parameter int ENTRIES = 16,
    parameter int QUEUES  = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sbmq_pkg::ctrl_cmd_t                  ctl,
    output sbmq_pkg::dp_stat_t                   stat,
    input  logic [sbmq_pkg::CMD_W-1:0]           in_cmd,
    input  logic [sbmq_pkg::QID_W-1:0]           in_qid,
    input  logic signed [sbmq_pkg::DATA_W-1:0]   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [sbmq_pkg::DATA_W-1:0]   out_data,
    output logic [sbmq_pkg::STATUS_W-1:0]        out_status
);

    // Pointers carry one extra code, ENTRIES, as null
    localparam int PW = $clog2(ENTRIES + 1);
    localparam int AW = $clog2(ENTRIES);
    localparam logic [PW-1:0] NIL = PW'(ENTRIES);

    // Queue pointers and free list
    logic [PW-1:0] head_reg [sbmq_pkg::QSLOTS];
    logic [PW-1:0] head_next [sbmq_pkg::QSLOTS];
    logic [PW-1:0] tail_reg [sbmq_pkg::QSLOTS];
    logic [PW-1:0] tail_next [sbmq_pkg::QSLOTS];
    logic [PW-1:0] free_head_reg;
    logic [PW-1:0] free_head_next;
    // Entries at or above the fill mark count as linking to i+1, whatever the link memory holds
    logic [PW-1:0] fill_reg;
    logic [PW-1:0] fill_next;

    // Captured operation
    logic [sbmq_pkg::CMD_W-1:0]         op_reg;
    logic [sbmq_pkg::QID_W-1:0]         qid_reg;
    logic signed [sbmq_pkg::DATA_W-1:0] din_reg;
    logic [PW-1:0]                      idx_reg;
    logic                               ok_reg;
    logic                               fresh_reg;

    // Result register
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [sbmq_pkg::DATA_W-1:0] out_data_reg;
    logic [sbmq_pkg::STATUS_W-1:0]      out_status_reg;

    // Capture-side decode
    logic          q_ok;
    logic [PW-1:0] head_cur;
    logic [PW-1:0] idx_cur;
    logic          ok_cur;

    // Memory ports
    logic          link_we;
    logic [AW-1:0] link_waddr;
    logic [PW-1:0] link_wdata;
    logic [PW-1:0] link_rdata;
    logic          data_we;
    logic          data_re;
    logic signed [sbmq_pkg::DATA_W-1:0] data_rdata;
    logic [PW-1:0] link_val;

    // Decode the operation at capture
    always_comb
    begin
        q_ok     = (32'(in_qid) < 32'(QUEUES));
        head_cur = head_reg[in_qid];
        if (in_cmd == sbmq_pkg::CMD_ENQ)
        begin
            idx_cur = free_head_reg;
            ok_cur  = q_ok && (free_head_reg != NIL);
        end
        else
        begin
            idx_cur = head_cur;
            ok_cur  = q_ok && (head_cur != NIL);
        end
    end

    assign data_re = ctl.capture && ok_cur && (in_cmd == sbmq_pkg::CMD_DEQ);

    // Successor of the entry in work
    assign link_val = fresh_reg ? (idx_reg + PW'(1)) : link_rdata;

    sbmq_ram #(
        .WIDTH (PW),
        .DEPTH (ENTRIES)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (ctl.capture && ok_cur),
        .raddr (idx_cur[AW-1:0]),
        .rdata (link_rdata)
    );

    sbmq_ram #(
        .WIDTH (sbmq_pkg::DATA_W),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (idx_reg[AW-1:0]),
        .wdata (din_reg),
        .re    (data_re),
        .raddr (idx_cur[AW-1:0]),
        .rdata (data_rdata)
    );

    // Commit: relink pointers, write memories
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        link_we        = 1'b0;
        link_waddr     = idx_reg[AW-1:0];
        link_wdata     = free_head_reg;
        data_we        = 1'b0;
        if (ctl.commit && ok_reg)
        begin
            if (op_reg == sbmq_pkg::CMD_ENQ)
            begin
                free_head_next = link_val;
                if (fresh_reg)
                begin
                    fill_next = fill_reg + PW'(1);
                end
                if (head_reg[qid_reg] == NIL)
                begin
                    head_next[qid_reg] = idx_reg;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_reg[qid_reg][AW-1:0];
                    link_wdata = idx_reg;
                end
                tail_next[qid_reg] = idx_reg;
                data_we            = 1'b1;
            end
            else
            begin
                // Last entry of the queue leaves it empty
                head_next[qid_reg] = (idx_reg == tail_reg[qid_reg]) ? NIL : link_val;
                link_we            = 1'b1;
                link_waddr         = idx_reg[AW-1:0];
                link_wdata         = free_head_reg;
                free_head_next     = idx_reg;
            end
        end
    end

    // Result valid: set on commit, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sbmq_pkg::QSLOTS; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
            free_head_reg <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the captured operation
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg    <= in_cmd;
            qid_reg   <= in_qid;
            din_reg   <= in_data;
            idx_reg   <= idx_cur;
            ok_reg    <= ok_cur;
            fresh_reg <= (idx_cur >= fill_reg);
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            if (op_reg == sbmq_pkg::CMD_ENQ)
            begin
                out_data_reg   <= '0;
                out_status_reg <= ok_reg ? sbmq_pkg::STATUS_OK : sbmq_pkg::STATUS_FULL;
            end
            else if (ok_reg)
            begin
                out_data_reg   <= data_rdata;
                out_status_reg <= sbmq_pkg::STATUS_OK;
            end
            else
            begin
                out_data_reg   <= '1;
                out_status_reg <= sbmq_pkg::STATUS_EMPTY;
            end
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign out_status    = out_status_reg;

endmodule

FILE: rtl/shared_buffer_multi_queue.sv
// Flow: a transfer is captured into the operation registers, then committed
// to the result register; commit waits while the last result is stalled.
// A new transfer is taken only once the previous item commits: the link and
// data memories are read at capture and written at commit in the datapath.
// Reset: asynchronous, active low; all queues empty, free list holds every
// entry in order, no clearing pass (a fill mark stands in for link reset).
module shared_buffer_multi_queue #(
    parameter int ENTRIES = 16,
    parameter int QUEUES  = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] data_in
    input  logic [2:0]  s_axis_tuser,   // [0] cmd, [2:1] queue_id
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] data_out
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    sbmq_pkg::ctrl_cmd_t ctl;
    sbmq_pkg::dp_stat_t  stat;
    logic signed [sbmq_pkg::DATA_W-1:0] out_data;

    sbmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    sbmq_dp #(
        .ENTRIES (ENTRIES),
        .QUEUES  (QUEUES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .in_cmd     (s_axis_tuser[0]),
        .in_qid     (s_axis_tuser[2:1]),
        .in_data    (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (out_data),
        .out_status (m_axis_tuser)
    );

    assign m_axis_tdata = out_data;

endmodule

FILE: rtl/sbmq_checker.sv
module sbmq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // Stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // One item in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("transfer taken while previous item in work");

    // A fresh result is preceded by its input transfer
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without matching input transfer");

    // Refused enqueue returns zero
    a_full_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == sbmq_pkg::STATUS_FULL) |-> m_axis_tdata == 32'd0)
        else $error("store full result carries data");

    // Empty dequeue returns all ones
    a_empty_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == sbmq_pkg::STATUS_EMPTY) |-> m_axis_tdata == '1)
        else $error("queue empty result not all ones");

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (.*);
